// ----- rtl/core/tsc_pkg.sv -----
package tsc_pkg;

   localparam int RING_DEPTH_DEFAULT = 65536;
   localparam int REF_LENGTH_DEFAULT = 32;
   localparam int MAX_REPEAT_DEFAULT = 16;

   localparam int SAMPLE_W    = 16;
   localparam int SIGN_MSB    = SAMPLE_W - 1;
   localparam int RING_ADDR_W = 16;
   localparam int FRAC_W      = 16;
   localparam int CORR_W      = 10;
   localparam int CORR_MAX    = (1 << CORR_W) - 1;

   localparam logic [31:0] REF_SIGNS_RESET = 32'hFFFF_0000;

   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_SKIP  = 2'd1;
   localparam logic [1:0] CMD_ZSKIP = 2'd2;
   localparam logic [1:0] CMD_CORR  = 2'd3;

   typedef struct packed {
      logic                   write_en;
      logic [RING_ADDR_W-1:0] addr;
      logic [SAMPLE_W-1:0]    wdata;
   } tsc_ring_req_type;

endpackage

// ----- rtl/core/tone_sign_correlator.sv -----
// One-bit sign correlator over a ring of signed 16-bit audio samples held in a
// single-port ring memory, one transaction in and one result out per command.
// A write or a skip passes from acceptance through the done state to the result
// register. A zero-crossing skip reads both ends of its range, checks them for a
// sign change and, if there is one, halves the bracket step by step before it picks an end. A
// correlate walks repeat_count * REF_LENGTH ring positions, one ring read per
// cycle, then drains and finishes. The ring has no reset and no clearing pass:
// entries read before being written hold whatever the memory holds. A finished
// result waits in the output register while the next command is accepted.
module tone_sign_correlator #(
   parameter int RING_DEPTH = tsc_pkg::RING_DEPTH_DEFAULT,
   parameter int REF_LENGTH = tsc_pkg::REF_LENGTH_DEFAULT,
   parameter int MAX_REPEAT = tsc_pkg::MAX_REPEAT_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  logic [31:0]                       csr_write_data,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_command,
   input  logic signed [tsc_pkg::SAMPLE_W-1:0] req_sample,
   input  logic [15:0]                       req_offset,
   input  logic [15:0]                       req_search_range,
   input  logic [23:0]                       req_step,
   input  logic [4:0]                        req_repeat_count,
   input  logic [23:0]                       req_skew,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [tsc_pkg::CORR_W-1:0]        rsp_correlation,
   output logic [15:0]                       rsp_advanced,
   output logic [15:0]                       rsp_read_position,
   output logic [15:0]                       rsp_fill_level,
   output logic                              rsp_overflow
);
   import tsc_pkg::*;

   localparam int PTR_W     = $clog2(RING_DEPTH);
   localparam int POS_W     = PTR_W + FRAC_W;
   localparam int REF_IDX_W = $clog2(REF_LENGTH);
   localparam int REP_W     = $clog2(MAX_REPEAT + 1);
   localparam int SUM_W     = $clog2(MAX_REPEAT * REF_LENGTH + 1) + 1;
   localparam int ZC_W      = 18;

   localparam logic [REF_IDX_W-1:0] REF_LAST = REF_IDX_W'(REF_LENGTH - 1);
   localparam logic [PTR_W-1:0]     PTR_FULL = {PTR_W{1'b1}};

   localparam logic [3:0] ST_IDLE       = 4'd0;
   localparam logic [3:0] ST_DONE       = 4'd1;
   localparam logic [3:0] ST_ZC_RDLO    = 4'd2;
   localparam logic [3:0] ST_ZC_RDHI    = 4'd3;
   localparam logic [3:0] ST_ZC_CHK     = 4'd4;
   localparam logic [3:0] ST_ZC_MID     = 4'd5;
   localparam logic [3:0] ST_ZC_CMP     = 4'd6;
   localparam logic [3:0] ST_ZC_PICK    = 4'd7;
   localparam logic [3:0] ST_CORR_RUN   = 4'd8;
   localparam logic [3:0] ST_CORR_DRAIN = 4'd9;
   localparam logic [3:0] ST_CORR_FIN   = 4'd10;

   logic [3:0]              state_ff, state_in;
   logic [PTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [1:0]              cmd_ff, cmd_in;
   logic [ZC_W-1:0]         lo_ff, lo_in;
   logic [ZC_W-1:0]         hi_ff, hi_in;
   logic [SAMPLE_W-1:0]     a_ff, a_in;
   logic [SAMPLE_W-1:0]     b_ff, b_in;
   logic [POS_W-1:0]        pos_ff, pos_in;
   logic [POS_W-1:0]        step_ff, step_in;
   logic [REF_IDX_W-1:0]    ref_idx_ff, ref_idx_in;
   logic [REP_W-1:0]        rep_left_ff, rep_left_in;
   logic                    acc_valid_ff, acc_valid_in;
   logic                    ref_bit_ff, ref_bit_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic [CORR_W-1:0]       corr_ff, corr_in;
   logic [15:0]             adv_ff, adv_in;
   logic                    ovf_ff, ovf_in;
   logic [31:0]             ref_signs_ff, ref_signs_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [CORR_W-1:0]       rsp_corr_ff, rsp_corr_in;
   logic [15:0]             rsp_adv_ff, rsp_adv_in;
   logic [15:0]             rsp_rdpos_ff, rsp_rdpos_in;
   logic [15:0]             rsp_fill_ff, rsp_fill_in;
   logic                    rsp_ovf_ff, rsp_ovf_in;

   tsc_ring_req_type        ring_req;
   logic [SAMPLE_W-1:0]     ring_rdata;

   logic                    req_accept;
   logic [PTR_W-1:0]        fill;
   logic [ZC_W-1:0]         mid;
   logic [15:0]             range_clamped;
   logic [ZC_W-1:0]         zc_centre;
   logic [6:0]              count_wide;
   logic [6:0]              count_clamped;
   logic [6:0]              ref_idx_wide;
   logic [SAMPLE_W-1:0]     key_a;
   logic [SAMPLE_W-1:0]     key_b;
   logic [ZC_W-1:0]         target;
   logic [SUM_W-1:0]        sum_mag;
   logic                    slot_free;

   tsc_ring #(
      .RING_DEPTH (RING_DEPTH)
   ) u_ring (
      .clock    (clock),
      .ring_req (ring_req),
      .rdata    (ring_rdata)
   );

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != ST_IDLE);
   assign fill       = wr_ptr_ff - rd_ptr_ff;
   assign mid        = ZC_W'(({1'b0, lo_ff} + {1'b0, hi_ff}) >> 1);
   assign slot_free  = !rsp_valid_ff || !rsp_stall;

   assign range_clamped = (req_search_range > req_offset) ? req_offset : req_search_range;
   assign zc_centre     = ZC_W'(rd_ptr_ff) + ZC_W'(req_offset);
   assign count_wide    = 7'(req_repeat_count);
   assign ref_idx_wide  = 7'(ref_idx_ff);

   assign key_a   = a_ff[SIGN_MSB] ? ~a_ff : a_ff;
   assign key_b   = b_ff[SIGN_MSB] ? ~b_ff : b_ff;
   assign target  = (key_a < key_b) ? lo_ff : hi_ff;
   assign sum_mag = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);

   always_comb begin
      if (count_wide == 7'd0) begin
         count_clamped = 7'd1;
      end else if (count_wide > 7'(MAX_REPEAT)) begin
         count_clamped = 7'(MAX_REPEAT);
      end else begin
         count_clamped = count_wide;
      end
   end

   always_comb begin
      ring_req.write_en = 1'b0;
      ring_req.addr     = RING_ADDR_W'(wr_ptr_ff);
      ring_req.wdata    = req_sample;
      unique case (state_ff)
         ST_IDLE: begin
            ring_req.write_en = req_accept && (req_command == CMD_WRITE) && (fill != PTR_FULL);
         end
         ST_ZC_RDLO:  ring_req.addr = RING_ADDR_W'(lo_ff[PTR_W-1:0]);
         ST_ZC_RDHI:  ring_req.addr = RING_ADDR_W'(hi_ff[PTR_W-1:0]);
         ST_ZC_MID:   ring_req.addr = RING_ADDR_W'(mid[PTR_W-1:0]);
         ST_CORR_RUN: ring_req.addr = RING_ADDR_W'(pos_ff[POS_W-1:FRAC_W]);
         default: begin
            ring_req.addr = RING_ADDR_W'(wr_ptr_ff);
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      rd_ptr_in    = rd_ptr_ff;
      wr_ptr_in    = wr_ptr_ff;
      cmd_in       = cmd_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      pos_in       = pos_ff;
      step_in      = step_ff;
      ref_idx_in   = ref_idx_ff;
      rep_left_in  = rep_left_ff;
      acc_valid_in = 1'b0;
      ref_bit_in   = ref_bit_ff;
      sum_in       = sum_ff;
      corr_in      = corr_ff;
      adv_in       = adv_ff;
      ovf_in       = ovf_ff;
      ref_signs_in = csr_write_enable ? csr_write_data : ref_signs_ff;

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_corr_in  = rsp_corr_ff;
      rsp_adv_in   = rsp_adv_ff;
      rsp_rdpos_in = rsp_rdpos_ff;
      rsp_fill_in  = rsp_fill_ff;
      rsp_ovf_in   = rsp_ovf_ff;

      if (acc_valid_ff) begin
         sum_in = (ring_rdata[SIGN_MSB] == ref_bit_ff) ? sum_ff + SUM_W'(1) : sum_ff - SUM_W'(1);
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               cmd_in  = req_command;
               corr_in = '0;
               adv_in  = '0;
               ovf_in  = 1'b0;
               unique case (req_command)
                  CMD_WRITE: begin
                     if (fill == PTR_FULL) begin
                        ovf_in = 1'b1;
                     end else begin
                        wr_ptr_in = wr_ptr_ff + PTR_W'(1);
                     end
                     state_in = ST_DONE;
                  end
                  CMD_SKIP: begin
                     adv_in = req_offset;
                     if ({1'b0, req_offset} < 17'(fill)) begin
                        rd_ptr_in = rd_ptr_ff + PTR_W'(req_offset);
                     end else begin
                        rd_ptr_in = wr_ptr_ff;
                     end
                     state_in = ST_DONE;
                  end
                  CMD_ZSKIP: begin
                     lo_in    = zc_centre - ZC_W'(range_clamped);
                     hi_in    = zc_centre + ZC_W'(range_clamped);
                     state_in = ST_ZC_RDLO;
                  end
                  CMD_CORR: begin
                     pos_in      = POS_W'({rd_ptr_ff, {FRAC_W{1'b0}}}) + POS_W'(req_skew);
                     step_in     = POS_W'(req_step);
                     ref_idx_in  = '0;
                     rep_left_in = REP_W'(count_clamped);
                     sum_in      = '0;
                     state_in    = ST_CORR_RUN;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_ZC_RDLO: state_in = ST_ZC_RDHI;
         ST_ZC_RDHI: begin
            a_in     = ring_rdata;
            state_in = ST_ZC_CHK;
         end
         ST_ZC_CHK: begin
            b_in     = ring_rdata;
            state_in = (a_ff[SIGN_MSB] != ring_rdata[SIGN_MSB]) ? ST_ZC_MID : ST_ZC_PICK;
         end
         ST_ZC_MID: begin
            state_in = (mid == lo_ff) ? ST_ZC_PICK : ST_ZC_CMP;
         end
         ST_ZC_CMP: begin
            if (a_ff[SIGN_MSB] != ring_rdata[SIGN_MSB]) begin
               hi_in = mid;
               b_in  = ring_rdata;
            end else begin
               lo_in = mid;
               a_in  = ring_rdata;
            end
            state_in = ST_ZC_MID;
         end
         ST_ZC_PICK: begin
            adv_in    = target[15:0] - 16'(rd_ptr_ff);
            rd_ptr_in = target[PTR_W-1:0];
            state_in  = ST_DONE;
         end
         ST_CORR_RUN: begin
            acc_valid_in = 1'b1;
            ref_bit_in   = ref_signs_ff[ref_idx_wide[4:0]];
            pos_in       = pos_ff + step_ff;
            if (ref_idx_ff == REF_LAST) begin
               ref_idx_in  = '0;
               rep_left_in = rep_left_ff - REP_W'(1);
               if (rep_left_ff == REP_W'(1)) begin
                  state_in = ST_CORR_DRAIN;
               end
            end else begin
               ref_idx_in = ref_idx_ff + REF_IDX_W'(1);
            end
         end
         ST_CORR_DRAIN: state_in = ST_CORR_FIN;
         ST_CORR_FIN: begin
            corr_in  = (32'(sum_mag) > 32'(CORR_MAX)) ? CORR_W'(CORR_MAX) : CORR_W'(sum_mag);
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_corr_in  = corr_ff;
               rsp_adv_in   = adv_ff;
               rsp_rdpos_in = 16'(rd_ptr_ff);
               rsp_fill_in  = 16'(fill);
               rsp_ovf_in   = ovf_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_ptr_ff    <= '0;
         wr_ptr_ff    <= '0;
         cmd_ff       <= CMD_WRITE;
         acc_valid_ff <= 1'b0;
         ref_signs_ff <= REF_SIGNS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_ptr_ff    <= rd_ptr_in;
         wr_ptr_ff    <= wr_ptr_in;
         cmd_ff       <= cmd_in;
         acc_valid_ff <= acc_valid_in;
         ref_signs_ff <= ref_signs_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      pos_ff       <= pos_in;
      step_ff      <= step_in;
      ref_idx_ff   <= ref_idx_in;
      rep_left_ff  <= rep_left_in;
      ref_bit_ff   <= ref_bit_in;
      sum_ff       <= sum_in;
      corr_ff      <= corr_in;
      adv_ff       <= adv_in;
      ovf_ff       <= ovf_in;
      rsp_corr_ff  <= rsp_corr_in;
      rsp_adv_ff   <= rsp_adv_in;
      rsp_rdpos_ff <= rsp_rdpos_in;
      rsp_fill_ff  <= rsp_fill_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_correlation   = rsp_corr_ff;
   assign rsp_advanced      = rsp_adv_ff;
   assign rsp_read_position = rsp_rdpos_ff;
   assign rsp_fill_level    = rsp_fill_ff;
   assign rsp_overflow      = rsp_ovf_ff;

   a_wr_ptr_hold: assert property (@(posedge clock) disable iff (reset)
      !(req_accept && (req_command == CMD_WRITE)) |=> $stable(wr_ptr_ff))
      else $error("write pointer moved without a write transaction");

   a_rd_ptr_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE && state_ff != ST_ZC_PICK) |=> $stable(rd_ptr_ff))
      else $error("read pointer moved outside skip handling");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DONE)
      else $error("result raised without a finished command");

   a_corr_only: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && corr_ff != '0) |-> cmd_ff == CMD_CORR)
      else $error("nonzero correlation for a non-correlate command");

   a_search_bracket: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ZC_MID) |-> (a_ff[SIGN_MSB] != b_ff[SIGN_MSB]) && (lo_ff < hi_ff))
      else $error("zero-cross search lost its sign change");

endmodule

// ----- rtl/core/tsc_ring.sv -----
module tsc_ring #(
   parameter int RING_DEPTH = tsc_pkg::RING_DEPTH_DEFAULT
) (
   input  logic                             clock,
   input  tsc_pkg::tsc_ring_req_type        ring_req,
   output logic [tsc_pkg::SAMPLE_W-1:0]     rdata
);
   import tsc_pkg::*;

   localparam int PTR_W = $clog2(RING_DEPTH);

   logic [SAMPLE_W-1:0] ring_mem [RING_DEPTH];
   logic [SAMPLE_W-1:0] rdata_ff;
   logic [PTR_W-1:0]    addr;

   assign addr  = ring_req.addr[PTR_W-1:0];
   assign rdata = rdata_ff;

   always_ff @(posedge clock) begin
      if (ring_req.write_en) begin
         ring_mem[addr] <= ring_req.wdata;
      end
      rdata_ff <= ring_mem[addr];
   end

endmodule

// ----- dv/tb_tone_sign_correlator.sv -----
module tb_tone_sign_correlator;
   import tsc_pkg::*;

   typedef struct {
      logic [1:0]  cmd_code;
      logic [15:0] pcm;
      logic [15:0] offset;
      logic [15:0] half_width;
      logic [23:0] stride;
      logic [4:0]  periods;
      logic [23:0] skew;
   } ring_cmd_t;

   typedef struct {
      logic [CORR_W-1:0] correlation;
      logic [15:0]       advanced;
      logic [15:0]       read_position;
      logic [15:0]       fill_level;
      logic              overflow;
   } ring_status_t;

   typedef struct {
      ring_cmd_t    cmd;
      ring_status_t status;
   } pending_cmd_t;

   logic clock;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [31:0] csr_write_data = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_command = CMD_WRITE;
   logic signed [SAMPLE_W-1:0] req_sample = '0;
   logic [15:0] req_offset = '0;
   logic [15:0] req_search_range = '0;
   logic [23:0] req_step = '0;
   logic [4:0] req_repeat_count = 5'd1;
   logic [23:0] req_skew = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [CORR_W-1:0] rsp_correlation;
   logic [15:0] rsp_advanced;
   logic [15:0] rsp_read_position;
   logic [15:0] rsp_fill_level;
   logic rsp_overflow;

   tone_sign_correlator i_dut (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_command       (req_command),
      .req_sample        (req_sample),
      .req_offset        (req_offset),
      .req_search_range  (req_search_range),
      .req_step          (req_step),
      .req_repeat_count  (req_repeat_count),
      .req_skew          (req_skew),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_correlation   (rsp_correlation),
      .rsp_advanced      (rsp_advanced),
      .rsp_read_position (rsp_read_position),
      .rsp_fill_level    (rsp_fill_level),
      .rsp_overflow      (rsp_overflow)
   );

   // shadow of the ring and its pointers
   logic [SAMPLE_W-1:0]    ring_mem [RING_DEPTH_DEFAULT];
   bit                     ring_written [RING_DEPTH_DEFAULT];
   logic [RING_ADDR_W-1:0] rd_ptr = '0;
   logic [RING_ADDR_W-1:0] wr_ptr = '0;
   logic [31:0]            ref_pattern = REF_SIGNS_RESET;
   bit                     probe_clean;

   int  tone_left = 0;
   bit  tone_neg = 1'b0;

   pending_cmd_t cmd_queue [$];
   ring_status_t status_queue [$];
   pending_cmd_t taken_cmd;
   ring_status_t want;

   int accept_count = 0;
   int taken_seen = 0;
   int mismatch_count = 0;
   int req_idle_pct = 0;
   int rsp_idle_pct = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [15:0] ring_fill();
      return wr_ptr - rd_ptr;
   endfunction

   function automatic logic [SAMPLE_W-1:0] ring_peek(logic [31:0] pos);
      probe_clean &= ring_written[pos[RING_ADDR_W-1:0]];
      return ring_mem[pos[RING_ADDR_W-1:0]];
   endfunction

   function automatic int clamp_periods(logic [4:0] p);
      if (p == 0) return 1;
      if (p > MAX_REPEAT_DEFAULT) return MAX_REPEAT_DEFAULT;
      return p;
   endfunction

   function automatic logic [31:0] crossing_target(logic [15:0] ofs, logic [15:0] hw);
      logic [31:0] mid, lo, hi;
      logic [SAMPLE_W-1:0] a, b, m;
      if (hw > ofs) hw = ofs;
      mid = {16'd0, rd_ptr} + ofs;
      lo = mid - hw;
      hi = mid + hw;
      a = ring_peek(lo);
      b = ring_peek(hi);
      if (a[SIGN_MSB] != b[SIGN_MSB]) begin
         mid = (lo + hi) >> 1;
         while (mid != lo) begin
            m = ring_peek(mid);
            if (a[SIGN_MSB] != m[SIGN_MSB]) begin
               hi = mid;
               b = m;
            end else begin
               lo = mid;
               a = m;
            end
            mid = (lo + hi) >> 1;
         end
         if (a[SIGN_MSB]) a = ~a;
         if (b[SIGN_MSB]) b = ~b;
      end else if (a[SIGN_MSB]) begin
         a = ~a;
         b = ~b;
      end
      return (a < b) ? lo : hi;
   endfunction

   function automatic logic [CORR_W-1:0] sign_correlation(logic [23:0] stride,
                                                          logic [4:0] periods,
                                                          logic [23:0] skew);
      logic [31:0] pos;
      logic [SAMPLE_W-1:0] s;
      int sum, n, total;
      total = clamp_periods(periods) * REF_LENGTH_DEFAULT;
      pos = {rd_ptr, 16'd0} + {8'd0, skew};
      sum = 0;
      for (n = 0; n < total; n++) begin
         s = ring_peek({16'd0, pos[31:16]});
         if (s[SIGN_MSB] == ref_pattern[n % $bits(ref_pattern)]) sum++;
         else sum--;
         pos = pos + {8'd0, stride};
      end
      if (sum < 0) sum = -sum;
      if (sum > CORR_MAX) sum = CORR_MAX;
      return sum[CORR_W-1:0];
   endfunction

   function automatic bit reads_written(ring_cmd_t c);
      logic [31:0] target;
      logic [CORR_W-1:0] corr;
      probe_clean = 1'b1;
      if (c.cmd_code == CMD_ZSKIP) target = crossing_target(c.offset, c.half_width);
      else if (c.cmd_code == CMD_CORR) corr = sign_correlation(c.stride, c.periods, c.skew);
      return probe_clean;
   endfunction

   function automatic ring_status_t predict_status(ring_cmd_t c);
      ring_status_t st;
      logic [31:0] target;
      st = '{default: '0};
      case (c.cmd_code)
         CMD_WRITE: begin
            if (ring_fill() == 16'hFFFF) begin
               st.overflow = 1'b1;
            end else begin
               ring_mem[wr_ptr] = c.pcm;
               ring_written[wr_ptr] = 1'b1;
               wr_ptr = wr_ptr + 1'b1;
            end
         end
         CMD_SKIP: begin
            st.advanced = c.offset;
            if (c.offset < ring_fill()) rd_ptr = rd_ptr + c.offset;
            else rd_ptr = wr_ptr;
         end
         CMD_ZSKIP: begin
            target = crossing_target(c.offset, c.half_width);
            st.advanced = target[15:0] - rd_ptr;
            rd_ptr = target[15:0];
         end
         default: begin
            st.correlation = sign_correlation(c.stride, c.periods, c.skew);
         end
      endcase
      st.read_position = rd_ptr;
      st.fill_level = ring_fill();
      return st;
   endfunction

   function automatic logic [15:0] tone_sample();
      logic [15:0] mag;
      mag = $urandom_range(0, 32767);
      if (tone_left == 0) begin
         tone_neg = !tone_neg;
         tone_left = $urandom_range(1, 24);
      end
      tone_left--;
      case ($urandom_range(0, 9))
         0, 1: return $urandom;
         2: begin
            case ($urandom_range(0, 3))
               0: return 16'h8000;
               1: return 16'h7FFF;
               2: return 16'h0000;
               default: return 16'hFFFF;
            endcase
         end
         default: return tone_neg ? ~mag : mag;
      endcase
   endfunction

   function automatic ring_cmd_t make_cmd(logic [1:0] code, logic [15:0] pcm,
                                          logic [15:0] ofs, logic [15:0] hw,
                                          logic [23:0] stride, logic [4:0] periods,
                                          logic [23:0] skew);
      ring_cmd_t c;
      c.cmd_code = code;
      c.pcm = pcm;
      c.offset = ofs;
      c.half_width = hw;
      c.stride = stride;
      c.periods = periods;
      c.skew = skew;
      return c;
   endfunction

   task automatic push_cmd(ring_cmd_t c);
      pending_cmd_t p;
      p.cmd = c;
      p.status = predict_status(c);
      cmd_queue.push_back(p);
   endtask

   task automatic random_cmd(bit wide);
      ring_cmd_t c;
      int fill, room, skew_int, span, pick, tries;
      bit shape, ok;
      fill = ring_fill();
      ok = 1'b0;
      for (tries = 0; tries < 8 && !ok; tries++) begin
         shape = !wide && ($urandom_range(0, 19) != 0);
         c.pcm = $urandom;
         c.offset = $urandom;
         c.half_width = $urandom;
         c.stride = $urandom;
         c.periods = $urandom;
         c.skew = $urandom;
         pick = $urandom_range(0, 99);
         if (pick < 30 || (shape && fill < 40 && pick < 75)) begin
            c.cmd_code = CMD_WRITE;
            c.pcm = tone_sample();
         end else if (pick < 45) begin
            c.cmd_code = CMD_SKIP;
            if (shape) begin
               if ($urandom_range(0, 4) == 0) c.offset = fill + $urandom_range(0, 8);
               else c.offset = $urandom_range(0, fill / 4);
            end
         end else if (pick < 70) begin
            c.cmd_code = CMD_ZSKIP;
            if (shape && fill > 0) begin
               c.offset = $urandom_range(0, fill - 1);
               room = fill - 1 - c.offset;
               if (room >= c.offset && $urandom_range(0, 7) == 0)
                  c.half_width = $urandom_range(c.offset, 65535);
               else
                  c.half_width = $urandom_range(0, (room < c.offset) ? room : c.offset);
            end
         end else begin
            c.cmd_code = CMD_CORR;
            case ($urandom_range(0, 9))
               0: c.periods = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(17, 31);
               1, 2: c.periods = $urandom_range(5, 16);
               default: c.periods = $urandom_range(1, 4);
            endcase
            if (shape && fill > 0) begin
               skew_int = $urandom_range(0, (fill > 256) ? 255 : fill - 1);
               c.skew[23:16] = skew_int[7:0];
               span = ((fill - 1 - skew_int) << 16) /
                      (clamp_periods(c.periods) * REF_LENGTH_DEFAULT);
               c.stride = $urandom_range(0, (span > 24'hFFFFFF) ? 24'hFFFFFF : span);
            end
         end
         ok = reads_written(c);
      end
      if (!ok) begin
         c.cmd_code = CMD_WRITE;
         c.pcm = tone_sample();
      end
      push_cmd(c);
   endtask

   task automatic wait_drained();
      do @(negedge clock); while (cmd_queue.size() != 0 || status_queue.size() != 0);
   endtask

   task automatic load_ref_signs(logic [31:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      ref_pattern = value;
   endtask

   task automatic check_field(string name, logic [31:0] expected_v, logic [31:0] actual_v);
      if (expected_v !== actual_v) begin
         $display("%0t: %s expected %0d actual %0d", $time, name, expected_v, actual_v);
         mismatch_count++;
      end
   endtask

   // driver: hold payload until the transaction is accepted
   always @(negedge clock) begin
      if (!req_valid || accept_count != taken_seen) begin
         taken_seen = accept_count;
         if (cmd_queue.size() != 0 && $urandom_range(0, 99) >= req_idle_pct) begin
            req_valid <= 1'b1;
            req_command <= cmd_queue[0].cmd.cmd_code;
            req_sample <= cmd_queue[0].cmd.pcm;
            req_offset <= cmd_queue[0].cmd.offset;
            req_search_range <= cmd_queue[0].cmd.half_width;
            req_step <= cmd_queue[0].cmd.stride;
            req_repeat_count <= cmd_queue[0].cmd.periods;
            req_skew <= cmd_queue[0].cmd.skew;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         taken_cmd = cmd_queue.pop_front();
         status_queue.push_back(taken_cmd.status);
         accept_count++;
      end
   end

   // result stall, with one long hold-off to back up the input
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (!hold_done && accept_count >= 150) begin
         hold_done = 1'b1;
         hold_left = 400;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < rsp_idle_pct);
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (status_queue.size() == 0) begin
            $display("%0t: result with nothing expected, correlation %0d advanced %0d",
                     $time, rsp_correlation, rsp_advanced);
            mismatch_count++;
         end else begin
            want = status_queue.pop_front();
            check_field("correlation", want.correlation, rsp_correlation);
            check_field("advanced", want.advanced, rsp_advanced);
            check_field("read_position", want.read_position, rsp_read_position);
            check_field("fill_level", want.fill_level, rsp_fill_level);
            check_field("overflow", want.overflow, rsp_overflow);
         end
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      req_idle_pct = 37;
      rsp_idle_pct = 59;
      push_cmd(make_cmd(CMD_SKIP, 16'h0000, 16'd0, 16'd0, 24'd0, 5'd1, 24'd0));
      push_cmd(make_cmd(CMD_SKIP, 16'h0000, 16'd5, 16'd0, 24'd0, 5'd1, 24'd0));
      push_cmd(make_cmd(CMD_WRITE, 16'h7FFF, 16'd0, 16'd0, 24'd0, 5'd1, 24'd0));
      push_cmd(make_cmd(CMD_WRITE, 16'h00C8, 16'd0, 16'd0, 24'd0, 5'd1, 24'd0));
      push_cmd(make_cmd(CMD_WRITE, 16'h0003, 16'd0, 16'd0, 24'd0, 5'd1, 24'd0));
      push_cmd(make_cmd(CMD_WRITE, 16'h0000, 16'd0, 16'd0, 24'd0, 5'd1, 24'd0));
      push_cmd(make_cmd(CMD_WRITE, 16'hFFFF, 16'd0, 16'd0, 24'd0, 5'd1, 24'd0));
      push_cmd(make_cmd(CMD_WRITE, 16'hFFFE, 16'd0, 16'd0, 24'd0, 5'd1, 24'd0));
      push_cmd(make_cmd(CMD_WRITE, 16'hFED4, 16'd0, 16'd0, 24'd0, 5'd1, 24'd0));
      push_cmd(make_cmd(CMD_WRITE, 16'h8000, 16'd0, 16'd0, 24'd0, 5'd1, 24'd0));
      push_cmd(make_cmd(CMD_WRITE, 16'h0005, 16'd0, 16'd0, 24'd0, 5'd1, 24'd0));
      push_cmd(make_cmd(CMD_WRITE, 16'h0007, 16'd0, 16'd0, 24'd0, 5'd1, 24'd0));
      push_cmd(make_cmd(CMD_CORR, 16'h0000, 16'd0, 16'd0, 24'd0, 5'd1, 24'd0));
      push_cmd(make_cmd(CMD_CORR, 16'h0000, 16'd0, 16'd0, 24'h004000, 5'd0, 24'h010000));
      push_cmd(make_cmd(CMD_CORR, 16'h0000, 16'd0, 16'd0, 24'd0, 5'd31, 24'h028000));
      push_cmd(make_cmd(CMD_ZSKIP, 16'h0000, 16'd3, 16'd3, 24'd0, 5'd1, 24'd0));
      push_cmd(make_cmd(CMD_ZSKIP, 16'h0000, 16'd2, 16'd40, 24'd0, 5'd1, 24'd0));
      push_cmd(make_cmd(CMD_ZSKIP, 16'h0000, 16'd0, 16'd0, 24'd0, 5'd1, 24'd0));
      push_cmd(make_cmd(CMD_SKIP, 16'h0000, 16'hFFFF, 16'd0, 24'd0, 5'd1, 24'd0));
      push_cmd(make_cmd(CMD_WRITE, 16'h8000, 16'd0, 16'd0, 24'd0, 5'd1, 24'd0));
      push_cmd(make_cmd(CMD_CORR, 16'h0000, 16'd0, 16'd0, 24'd0, 5'd2, 24'd0));
      push_cmd(make_cmd(CMD_WRITE, 16'h7FFF, 16'd0, 16'd0, 24'd0, 5'd1, 24'd0));
      push_cmd(make_cmd(CMD_ZSKIP, 16'h0000, 16'd0, 16'hFFFF, 24'd0, 5'd1, 24'd0));
      wait_drained();

      load_ref_signs(32'h0000_0000);
      repeat (390) random_cmd(1'b0);
      wait_drained();

      load_ref_signs(32'hFFFF_FFFF);
      req_idle_pct = 59;
      rsp_idle_pct = 37;
      repeat (195) random_cmd(1'b0);
      wait_drained();
      repeat (195) random_cmd(1'b0);
      wait_drained();

      load_ref_signs($urandom);
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      repeat (390) random_cmd(1'b0);
      wait_drained();

      // fill the ring to the brim, then overrun it
      load_ref_signs($urandom);
      while (ring_fill() != 16'hFFFF)
         push_cmd(make_cmd(CMD_WRITE, tone_sample(), 16'd0, 16'd0, 24'd0, 5'd1, 24'd0));
      repeat (3) push_cmd(make_cmd(CMD_WRITE, $urandom, 16'd0, 16'd0, 24'd0, 5'd1, 24'd0));
      repeat (150) random_cmd(1'b1);
      wait_drained();

      repeat (600) @(posedge clock);
      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #60000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/core/tsc_pkg.sv
rtl/core/tsc_ring.sv
rtl/core/tone_sign_correlator.sv
dv/tb_tone_sign_correlator.sv
